[design/bafa_pkg.sv]
// Shared types and constants for the bit array field access block.
package bafa_pkg;

    localparam int OPCODE_W = 3;
    localparam int POS_W = 9;
    localparam int WIDTH_W = 5;
    localparam int VALUE_W = 25;
    localparam int BYTE_W = 8;
    localparam int WINDOW_W = 32;
    localparam int BYTE_IDX_W = POS_W - 3;

    localparam int DEF_STORE_BYTES = 64;
    localparam int DEF_MAX_FIELD_BITS = 25;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET     = 3'd0,
        OP_CLEAR   = 3'd1,
        OP_GET     = 3'd2,
        OP_EXTRACT = 3'd3,
        OP_INSERT  = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_READ,
        S_SETTLE,
        S_MERGE,
        S_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } store_cmd_t;

endpackage

[design/bafa_if.sv]
// Request and response channel interfaces for the bit array field access block.
interface bafa_req_if;
    logic                           valid;
    logic                           ready;
    logic [bafa_pkg::OPCODE_W-1:0]  opcode;
    logic [bafa_pkg::POS_W-1:0]     bit_position;
    logic [bafa_pkg::WIDTH_W-1:0]   field_width;
    logic [bafa_pkg::VALUE_W-1:0]   write_value;

    modport source (output valid, output opcode, output bit_position,
                    output field_width, output write_value, input ready);
    modport sink (input valid, input opcode, input bit_position,
                  input field_width, input write_value, output ready);
endinterface

interface bafa_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bafa_pkg::VALUE_W-1:0]   read_value;

    modport source (output valid, output read_value, input ready);
    modport sink (input valid, input read_value, output ready);
endinterface

[design/bit_array_field_access.sv]
// Bit array field access: set, clear, get bit and extract/insert fields in a byte store.
// The block serves one request at a time through a byte-serial sequencer on a single
// store port. After a request transfer it reduces the start byte into the store (by
// repeated subtraction of STORE_BYTES when the store holds fewer than 64 bytes), reads
// the four window bytes one per cycle, merges them, and for set, clear and insert writes
// the four bytes back one per cycle. The result waits until the output register is free,
// and the next request is taken in the cycle the result appears. The store reads as all
// zero after reset, with no clearing pass.
module bit_array_field_access #(
    parameter int STORE_BYTES    = bafa_pkg::DEF_STORE_BYTES,
    parameter int MAX_FIELD_BITS = bafa_pkg::DEF_MAX_FIELD_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    bafa_req_if.sink    req,
    bafa_rsp_if.source  rsp
);

    bafa_pkg::store_cmd_t             cmd;
    logic [$clog2(STORE_BYTES)-1:0]   mem_addr;
    logic [bafa_pkg::BYTE_W-1:0]      mem_wdata;
    logic [bafa_pkg::BYTE_W-1:0]      mem_rdata;

    bafa_ctrl #(
        .STORE_BYTES    (STORE_BYTES),
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    bafa_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

[design/bafa_ram.sv]
// Generic single-port-write, registered-read RAM.
module bafa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/bafa_store.sv]
// Byte store: RAM plus per-byte written flags so unwritten bytes read as zero.
module bafa_store #(
    parameter int STORE_BYTES = bafa_pkg::DEF_STORE_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bafa_pkg::store_cmd_t           cmd,
    input  logic [$clog2(STORE_BYTES)-1:0] addr,
    input  logic [bafa_pkg::BYTE_W-1:0]    wdata,
    output logic [bafa_pkg::BYTE_W-1:0]    rdata
);

    logic [STORE_BYTES-1:0]          valid_reg;
    logic [STORE_BYTES-1:0]          valid_next;
    logic                            rd_valid_reg;
    logic                            rd_valid_next;
    logic [bafa_pkg::BYTE_W-1:0]     ram_rdata;

    bafa_ram #(
        .WIDTH (bafa_pkg::BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (addr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        valid_next = valid_reg;
        rd_valid_next = rd_valid_reg;
        if (cmd.wr_en)
        begin
            valid_next[addr] = 1'b1;
        end
        if (cmd.rd_en)
        begin
            rd_valid_next = valid_reg[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // a byte never written since reset reads as zero
    assign rdata = rd_valid_reg ? ram_rdata : '0;

endmodule

[design/bafa_ctrl.sv]
// Sequencer and shared window shift/merge unit for bit and field operations.
module bafa_ctrl #(
    parameter int STORE_BYTES    = bafa_pkg::DEF_STORE_BYTES,
    parameter int MAX_FIELD_BITS = bafa_pkg::DEF_MAX_FIELD_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bafa_req_if.sink                       req,
    bafa_rsp_if.source                     rsp,
    output bafa_pkg::store_cmd_t           cmd,
    output logic [$clog2(STORE_BYTES)-1:0] mem_addr,
    output logic [bafa_pkg::BYTE_W-1:0]    mem_wdata,
    input  logic [bafa_pkg::BYTE_W-1:0]    mem_rdata
);

    localparam int RAM_AW = $clog2(STORE_BYTES);
    localparam int WORK_AW = (RAM_AW > bafa_pkg::BYTE_IDX_W) ? RAM_AW : bafa_pkg::BYTE_IDX_W;
    localparam int VW = bafa_pkg::VALUE_W;
    localparam int WW = bafa_pkg::WINDOW_W;
    localparam int BW = bafa_pkg::BYTE_W;
    localparam int WDW = bafa_pkg::WIDTH_W;

    bafa_pkg::state_t state_reg, state_next;
    logic [WORK_AW-1:0] addr_reg, addr_next;
    logic [RAM_AW-1:0]  base_reg, base_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               out_valid_reg, out_valid_next;
    logic               wr_op_reg, wr_op_next;
    logic               keep_reg, keep_next;
    logic [2:0]         off_reg, off_next;
    logic [WDW-1:0]     width_reg, width_next;
    logic [VW-1:0]      value_reg, value_next;
    logic [WW-1:0]      win_reg, win_next;
    logic [VW-1:0]      result_reg, result_next;
    logic [VW-1:0]      out_value_reg, out_value_next;

    logic [WDW-1:0]     sat_width;
    logic [WORK_AW-1:0] addr_inc;
    logic [5:0]         shift_full;
    logic [4:0]         shift_amt;
    logic [VW:0]        fmask_full;
    logic [VW-1:0]      fmask;
    logic [WW-1:0]      mask_win;
    logic [WW-1:0]      ins_win;
    logic [WW-1:0]      merged_win;
    logic [WW-1:0]      ext_win;

    // width clamp to 1..MAX_FIELD_BITS
    always_comb
    begin
        if (req.field_width == '0)
        begin
            sat_width = WDW'(1);
        end
        else if (req.field_width > WDW'(MAX_FIELD_BITS))
        begin
            sat_width = WDW'(MAX_FIELD_BITS);
        end
        else
        begin
            sat_width = req.field_width;
        end
    end

    assign addr_inc = (addr_reg == WORK_AW'(STORE_BYTES - 1)) ? '0 : addr_reg + WORK_AW'(1);

    // shared shift unit: field sits (off) bits below the window's top bit
    assign shift_full = 6'd32 - {3'b000, off_reg} - {1'b0, width_reg};
    assign shift_amt  = shift_full[4:0];
    assign fmask_full = ((VW+1)'(1) << width_reg) - (VW+1)'(1);
    assign fmask      = fmask_full[VW-1:0];
    assign mask_win   = {{(WW-VW){1'b0}}, fmask} << shift_amt;
    assign ins_win    = {{(WW-VW){1'b0}}, value_reg & fmask} << shift_amt;
    assign merged_win = (win_reg & ~mask_win) | ins_win;
    assign ext_win    = win_reg >> shift_amt;

    always_comb
    begin
        state_next = state_reg;
        addr_next = addr_reg;
        base_next = base_reg;
        cnt_next = cnt_reg;
        rd_pend_next = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        wr_op_next = wr_op_reg;
        keep_next = keep_reg;
        off_next = off_reg;
        width_next = width_reg;
        value_next = value_reg;
        win_next = win_reg;
        result_next = result_reg;
        out_value_next = out_value_reg;
        cmd = '0;
        mem_addr = addr_reg[RAM_AW-1:0];
        mem_wdata = win_reg[WW-1 -: BW];
        req.ready = 1'b0;

        // shift in the byte read last cycle
        if (rd_pend_reg)
        begin
            win_next = {win_reg[WW-BW-1:0], mem_rdata};
        end

        case (state_reg)
            bafa_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    off_next = req.bit_position[2:0];
                    addr_next = WORK_AW'(req.bit_position[bafa_pkg::POS_W-1:3]);
                    cnt_next = '0;
                    case (req.opcode)
                        bafa_pkg::OP_SET:
                        begin
                            wr_op_next = 1'b1;
                            keep_next = 1'b0;
                            width_next = WDW'(1);
                            value_next = VW'(1);
                        end
                        bafa_pkg::OP_CLEAR:
                        begin
                            wr_op_next = 1'b1;
                            keep_next = 1'b0;
                            width_next = WDW'(1);
                            value_next = '0;
                        end
                        bafa_pkg::OP_GET:
                        begin
                            wr_op_next = 1'b0;
                            keep_next = 1'b1;
                            width_next = WDW'(1);
                            value_next = '0;
                        end
                        bafa_pkg::OP_EXTRACT:
                        begin
                            wr_op_next = 1'b0;
                            keep_next = 1'b1;
                            width_next = sat_width;
                            value_next = '0;
                        end
                        bafa_pkg::OP_INSERT:
                        begin
                            wr_op_next = 1'b1;
                            keep_next = 1'b0;
                            width_next = sat_width;
                            value_next = req.write_value;
                        end
                        default:
                        begin
                            wr_op_next = 1'b0;
                            keep_next = 1'b0;
                            width_next = WDW'(1);
                            value_next = '0;
                        end
                    endcase
                    state_next = bafa_pkg::S_WRAP;
                end
            end
            bafa_pkg::S_WRAP:
            begin
                // reduce the start byte into the store, one subtract a cycle
                if ({1'b0, addr_reg} >= (WORK_AW+1)'(STORE_BYTES))
                begin
                    addr_next = addr_reg - WORK_AW'(STORE_BYTES);
                end
                else
                begin
                    base_next = addr_reg[RAM_AW-1:0];
                    state_next = bafa_pkg::S_READ;
                end
            end
            bafa_pkg::S_READ:
            begin
                cmd.rd_en = 1'b1;
                rd_pend_next = 1'b1;
                addr_next = addr_inc;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = bafa_pkg::S_SETTLE;
                end
            end
            bafa_pkg::S_SETTLE:
            begin
                state_next = bafa_pkg::S_MERGE;
            end
            bafa_pkg::S_MERGE:
            begin
                win_next = merged_win;
                result_next = keep_reg ? (ext_win[VW-1:0] & fmask) : '0;
                addr_next = WORK_AW'(base_reg);
                cnt_next = '0;
                state_next = wr_op_reg ? bafa_pkg::S_WRITE : bafa_pkg::S_DONE;
            end
            bafa_pkg::S_WRITE:
            begin
                cmd.wr_en = 1'b1;
                win_next = {win_reg[WW-BW-1:0], {BW{1'b0}}};
                addr_next = addr_inc;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = bafa_pkg::S_DONE;
                end
            end
            bafa_pkg::S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = result_reg;
                    state_next = bafa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bafa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bafa_pkg::S_IDLE;
            addr_reg <= '0;
            cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg <= addr_next;
            cnt_reg <= cnt_next;
            rd_pend_reg <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        wr_op_reg <= wr_op_next;
        keep_reg <= keep_next;
        off_reg <= off_next;
        width_reg <= width_next;
        value_reg <= value_next;
        win_reg <= win_next;
        result_reg <= result_next;
        out_value_reg <= out_value_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.read_value = out_value_reg;

    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd_en && cmd.wr_en))
        else $error("store read and write in the same cycle");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while an item is in flight");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == bafa_pkg::S_DONE))
        else $error("response raised outside completion");

    a_addr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bafa_pkg::S_READ || state_reg == bafa_pkg::S_WRITE)
        |-> ({1'b0, addr_reg} < (WORK_AW+1)'(STORE_BYTES)))
        else $error("store address beyond the last byte");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the bit array field access block.
`timescale 1ns / 100ps

module testbench;

    localparam int OPCODE_W       = bafa_pkg::OPCODE_W;
    localparam int POS_W          = bafa_pkg::POS_W;
    localparam int WIDTH_W        = bafa_pkg::WIDTH_W;
    localparam int VALUE_W        = bafa_pkg::VALUE_W;
    localparam int BYTE_W         = bafa_pkg::BYTE_W;
    localparam int WINDOW_W       = bafa_pkg::WINDOW_W;
    localparam int STORE_BYTES    = bafa_pkg::DEF_STORE_BYTES;
    localparam int MAX_FIELD_BITS = bafa_pkg::DEF_MAX_FIELD_BITS;
    localparam int RANDOM_ITEMS   = 650;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int TAIL_CYCLES    = 24;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_RESULT = 200;
    localparam int PAUSE_AT_ITEM  = 400;
    localparam int REPORT_MAX     = 10;

    // Opcodes with no operation behind them
    localparam logic [OPCODE_W-1:0] OP_RESERVED_5 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_RESERVED_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RESERVED_7 = 3'd7;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [POS_W-1:0]    pos;
        logic [WIDTH_W-1:0]  width;
        logic [VALUE_W-1:0]  value;
        bit                  typed;
        logic [VALUE_W-1:0]  read_value;
    } access_row_t;

    typedef struct {
        int unsigned        tag;
        logic [VALUE_W-1:0] read_value;
    } read_expect_t;

    logic clk;
    logic rst_n;

    bafa_req_if req_ch ();
    bafa_rsp_if rsp_ch ();

    bit_array_field_access #(
        .STORE_BYTES    (STORE_BYTES),
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [BYTE_W-1:0] shadow_bytes [STORE_BYTES];
    read_expect_t      expected_reads [$];

    int unsigned requests_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned cycles;
    int unsigned op_counts [8];

    access_row_t directed_rows [23] = '{
        '{bafa_pkg::OP_GET,     9'd0,   5'd1,  25'h0000000, 1'b1, 25'd0},
        '{bafa_pkg::OP_EXTRACT, 9'd504, 5'd25, 25'h0000000, 1'b1, 25'd0},
        '{bafa_pkg::OP_SET,     9'd0,   5'd0,  25'h1FFFFFF, 1'b1, 25'd0},
        '{bafa_pkg::OP_GET,     9'd0,   5'd0,  25'h0000000, 1'b1, 25'd1},
        '{bafa_pkg::OP_SET,     9'd511, 5'd31, 25'h0000000, 1'b1, 25'd0},
        '{bafa_pkg::OP_GET,     9'd511, 5'd31, 25'h1FFFFFF, 1'b1, 25'd1},
        '{bafa_pkg::OP_INSERT,  9'd504, 5'd25, 25'h1FFFFFF, 1'b1, 25'd0},
        '{bafa_pkg::OP_EXTRACT, 9'd504, 5'd25, 25'h0000000, 1'b0, 25'd0},
        '{bafa_pkg::OP_EXTRACT, 9'd0,   5'd0,  25'h0000000, 1'b0, 25'd0},
        '{bafa_pkg::OP_INSERT,  9'd7,   5'd31, 25'h1555555, 1'b1, 25'd0},
        '{bafa_pkg::OP_EXTRACT, 9'd7,   5'd31, 25'h0000000, 1'b0, 25'd0},
        '{bafa_pkg::OP_CLEAR,   9'd7,   5'd0,  25'h0000000, 1'b1, 25'd0},
        '{bafa_pkg::OP_EXTRACT, 9'd0,   5'd25, 25'h0000000, 1'b0, 25'd0},
        '{OP_RESERVED_5,        9'd100, 5'd12, 25'h00ABCDE, 1'b1, 25'd0},
        '{OP_RESERVED_6,        9'd200, 5'd25, 25'h1FFFFFF, 1'b1, 25'd0},
        '{OP_RESERVED_7,        9'd511, 5'd31, 25'h1FFFFFF, 1'b1, 25'd0},
        '{bafa_pkg::OP_INSERT,  9'd100, 5'd3,  25'h1FFFFFF, 1'b1, 25'd0},
        '{bafa_pkg::OP_EXTRACT, 9'd99,  5'd7,  25'h0000000, 1'b0, 25'd0},
        '{bafa_pkg::OP_INSERT,  9'd261, 5'd1,  25'h0000000, 1'b1, 25'd0},
        '{bafa_pkg::OP_EXTRACT, 9'd256, 5'd25, 25'h0000000, 1'b0, 25'd0},
        '{bafa_pkg::OP_CLEAR,   9'd511, 5'd0,  25'h0000000, 1'b1, 25'd0},
        '{bafa_pkg::OP_GET,     9'd511, 5'd0,  25'h0000000, 1'b1, 25'd0},
        '{bafa_pkg::OP_EXTRACT, 9'd511, 5'd25, 25'h0000000, 1'b0, 25'd0}
    };

    // Apply one request to the shadow store and return the value it reads back
    function automatic logic [VALUE_W-1:0] apply_access(
        logic [OPCODE_W-1:0] op,
        logic [POS_W-1:0]    pos,
        logic [WIDTH_W-1:0]  width,
        logic [VALUE_W-1:0]  value
    );
        int unsigned         base;
        int unsigned         off;
        int unsigned         fbits;
        int unsigned         shift;
        logic [WINDOW_W-1:0] window;
        logic [WINDOW_W-1:0] fmask;
        logic [WINDOW_W-1:0] result;
        base   = pos[POS_W-1:3] % STORE_BYTES;
        off    = pos[2:0];
        fbits  = width;
        result = '0;
        if (fbits < 1)
            fbits = 1;
        if (fbits > MAX_FIELD_BITS)
            fbits = MAX_FIELD_BITS;
        shift  = WINDOW_W - off - fbits;
        fmask  = (WINDOW_W'(1) << fbits) - 1;
        window = '0;
        for (int k = 0; k < 4; k++)
            window = (window << BYTE_W) | WINDOW_W'(shadow_bytes[(base + k) % STORE_BYTES]);
        case (op)
            bafa_pkg::OP_SET:     shadow_bytes[base][7 - off] = 1'b1;
            bafa_pkg::OP_CLEAR:   shadow_bytes[base][7 - off] = 1'b0;
            bafa_pkg::OP_GET:     result = WINDOW_W'(shadow_bytes[base][7 - off]);
            bafa_pkg::OP_EXTRACT: result = (window >> shift) & fmask;
            bafa_pkg::OP_INSERT:
            begin
                window = (window & ~(fmask << shift)) |
                         ((WINDOW_W'(value) & fmask) << shift);
                for (int k = 0; k < 4; k++)
                    shadow_bytes[(base + k) % STORE_BYTES] = window[WINDOW_W-1-8*k -: BYTE_W];
            end
            default: ;
        endcase
        return result[VALUE_W-1:0];
    endfunction

    // Mostly short gaps, some medium, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_access(
        logic [OPCODE_W-1:0] op,
        logic [POS_W-1:0]    pos,
        logic [WIDTH_W-1:0]  width,
        logic [VALUE_W-1:0]  value,
        bit                  typed,
        logic [VALUE_W-1:0]  typed_read,
        int unsigned         gap
    );
        read_expect_t        entry;
        logic [VALUE_W-1:0]  predicted;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.bit_position <= pos;
        req_ch.field_width  <= width;
        req_ch.write_value  <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted        = apply_access(op, pos, width, value);
        entry.tag        = requests_sent;
        entry.read_value = typed ? typed_read : predicted;
        expected_reads.push_back(entry);
        op_counts[op]++;
        requests_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold until every pending read has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_reads.size() != 0);
    endtask

    function automatic logic [POS_W-1:0] pick_position(int unsigned hot_base);
        if ($urandom_range(0, 1) == 0)
            return POS_W'($urandom_range(0, 511));
        return POS_W'(hot_base + $urandom_range(0, 47));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d reads pending",
                         cycles, expected_reads.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Response ready: random stalls, quiet stretches, and one long hold-off
    initial
    begin
        int unsigned stall_left;
        bit          held;
        logic        next_ready;
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        held         = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= HOLD_AT_RESULT)
            begin
                held       = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else if ((results_seen / 100) % 3 == 2)
                next_ready = 1'b1;
            else
            begin
                stall_left = pick_gap();
                next_ready = (stall_left == 0);
            end
            rsp_ch.ready <= next_ready;
        end
    end

    // Compare each read transfer with the oldest prediction
    initial
    begin
        read_expect_t entry;
        results_seen = 0;
        mismatches   = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_reads.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected read_value %h at cycle %0d",
                                 rsp_ch.read_value, cycles);
                end
                else
                begin
                    entry = expected_reads.pop_front();
                    if (rsp_ch.read_value !== entry.read_value)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("request %0d: read_value expected %h got %h",
                                     entry.tag, entry.read_value, rsp_ch.read_value);
                    end
                end
                results_seen++;
            end
        end
    end

    initial
    begin
        int unsigned         sent_random;
        int unsigned         hot_base;
        int unsigned         choice;
        bit                  paused;
        logic [POS_W-1:0]    pos;
        logic [WIDTH_W-1:0]  width;
        logic [OPCODE_W-1:0] op;
        requests_sent       = 0;
        foreach (op_counts[i])
            op_counts[i] = 0;
        foreach (shadow_bytes[i])
            shadow_bytes[i] = '0;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = bafa_pkg::OP_SET;
        req_ch.bit_position = '0;
        req_ch.field_width  = '0;
        req_ch.write_value  = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_access(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].width,
                        directed_rows[i].value, directed_rows[i].typed,
                        directed_rows[i].read_value, pick_gap());

        sent_random = 0;
        paused      = 1'b0;
        hot_base    = $urandom_range(0, 463);
        while (sent_random < RANDOM_ITEMS)
        begin
            if (sent_random % 50 == 0)
                hot_base = $urandom_range(0, 463);
            if (!paused && sent_random >= PAUSE_AT_ITEM)
            begin
                paused = 1'b1;
                wait_drained();
            end
            pos    = pick_position(hot_base);
            width  = WIDTH_W'($urandom_range(0, 31));
            choice = $urandom_range(0, 99);
            if (choice < 35)
            begin
                // insert, then read the same field back
                send_access(bafa_pkg::OP_INSERT, pos, width, VALUE_W'($urandom), 1'b0, '0,
                            (sent_random / 80) % 4 == 3 ? 0 : pick_gap());
                send_access(bafa_pkg::OP_EXTRACT, pos, width, VALUE_W'($urandom), 1'b0, '0,
                            pick_gap());
                sent_random += 2;
            end
            else if (choice < 50)
            begin
                send_access($urandom_range(0, 1) ? bafa_pkg::OP_SET : bafa_pkg::OP_CLEAR,
                            pos, width, VALUE_W'($urandom), 1'b0, '0, pick_gap());
                send_access(bafa_pkg::OP_GET, pos, WIDTH_W'($urandom), VALUE_W'($urandom),
                            1'b0, '0, pick_gap());
                sent_random += 2;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2:     op = bafa_pkg::OP_SET;
                    3, 4, 5:     op = bafa_pkg::OP_CLEAR;
                    6, 7, 8:     op = bafa_pkg::OP_GET;
                    9, 10, 11, 12, 13: op = bafa_pkg::OP_EXTRACT;
                    14, 15, 16, 17: op = bafa_pkg::OP_INSERT;
                    18:          op = OP_RESERVED_5;
                    default:     op = $urandom_range(0, 1) ? OP_RESERVED_6 : OP_RESERVED_7;
                endcase
                send_access(op, pos, width, VALUE_W'($urandom), 1'b0, '0,
                            (sent_random / 80) % 4 == 3 ? 0 : pick_gap());
                sent_random++;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d requests: set %0d, clear %0d, get %0d, extract %0d, insert %0d,",
                 requests_sent, op_counts[bafa_pkg::OP_SET], op_counts[bafa_pkg::OP_CLEAR],
                 op_counts[bafa_pkg::OP_GET], op_counts[bafa_pkg::OP_EXTRACT],
                 op_counts[bafa_pkg::OP_INSERT]);
        $display("  unused opcodes %0d; %0d reads checked, %0d mismatches",
                 op_counts[OP_RESERVED_5] + op_counts[OP_RESERVED_6] +
                 op_counts[OP_RESERVED_7], results_seen, mismatches);
        if (mismatches == 0 && expected_reads.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
design/bafa_pkg.sv
design/bafa_if.sv
design/bafa_ram.sv
design/bafa_store.sv
design/bafa_ctrl.sv
design/bit_array_field_access.sv
dv/testbench.sv
